// ===== sv/u16ss_pkg.sv =====
// Shared types and constants of the UTF-16 substring search block.
package u16ss_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int TEXT_MAX    = 65535;

    localparam int UNIT_W = 16;
    localparam int POS_W  = 16;
    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W  = $clog2(TEXT_MAX + 1);
    // Wide enough for count, offset and length sums without wrap.
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TEXT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef logic [PATTERN_MAX-1:0][UNIT_W-1:0] t_unit_arr;

    typedef struct packed {
        logic [1:0]        op;
        logic [UNIT_W-1:0] ch;
        logic              last;
        logic [POS_W-1:0]  start_at;
    } t_in_beat;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_res_beat;

endpackage

// ===== sv/u16ss_if.sv =====
// Valid/ready channel interfaces for input beats and result beats.
interface u16ss_in_if;
    import u16ss_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface u16ss_res_if;
    import u16ss_pkg::*;
    logic      valid;
    logic      ready;
    t_res_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/u16ss_match.sv =====
// Parallel compare of the text window against the reversed pattern.
module u16ss_match (
    input  u16ss_pkg::t_unit_arr         i_window,
    input  u16ss_pkg::t_unit_arr         i_pattern,
    input  logic [u16ss_pkg::LEN_W-1:0]  i_length,
    output logic                         o_match
);
    import u16ss_pkg::*;

    logic [PATTERN_MAX-1:0] w_ok;

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            w_ok[k] = (LEN_W'(k) >= i_length) || (i_window[k] == i_pattern[k]);
        end
    end

    assign o_match = &w_ok;

endmodule

// ===== sv/utf16_substring_search.sv =====
// A beat is taken into the input register; its result is then written to the output register.
// Throughput: one beat per cycle; a beat is held only while the result register is
// full and not drained, since every text beat may produce a result.
// Pattern is kept reversed in a shift line, so the window compare is one rank of
// fixed-position comparators and an AND tree. Reset (synchronous, active low) empties
// the pattern and ends any search; no clearing pass, pattern units need no reset.
module utf16_substring_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u16ss_in_if.sink    i_in,
    u16ss_res_if.source o_res
);
    import u16ss_pkg::*;

    // Input register stage
    logic     r_in_valid;
    t_in_beat r_in;

    // Search state
    t_unit_arr        r_window,  n_window;
    t_unit_arr        r_pat,     n_pat;     // entry 0 holds the last loaded unit
    logic [LEN_W-1:0] r_len,     n_len;
    logic             r_loading, n_loading;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [POS_W-1:0] r_offset,  n_offset;
    logic             r_done,    n_done;

    // Result register
    logic             r_out_valid;
    logic             r_found,   n_found;
    logic [POS_W-1:0] r_pos,     n_pos;

    logic             w_fire;
    logic             w_emit;
    logic             w_match;
    logic             w_pat_shift;
    logic             w_win_shift;

    // Process the held beat when the result register can take a result.
    assign w_fire     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    // Window with the held text unit pushed in as the newest entry.
    always_comb begin
        n_window[0] = r_in.ch;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_window[k] = r_window[k-1];
        end
        n_pat[0] = r_in.ch;
        for (int k = 1; k < PATTERN_MAX; k++) begin
            n_pat[k] = r_pat[k-1];
        end
    end

    u16ss_match u_match (
        .i_window  (n_window),
        .i_pattern (r_pat),
        .i_length  (r_len),
        .o_match   (w_match)
    );

    // Next-state and result logic for one beat.
    always_comb begin
        logic [LEN_W-1:0] len_base;
        logic [POS_W-1:0] offset;
        logic             done;
        logic [CNT_W-1:0] cnt_inc;
        logic             hit;

        n_len       = r_len;
        n_loading   = r_loading;
        n_count     = r_count;
        n_offset    = r_offset;
        n_done      = r_done;
        n_found     = 1'b0;
        n_pos       = '0;
        w_emit      = 1'b0;
        w_pat_shift = 1'b0;
        w_win_shift = 1'b0;
        len_base    = r_loading ? r_len : '0;
        offset      = (r_count == '0) ? r_in.start_at : r_offset;
        done        = (r_count == '0) ? 1'b0 : r_done;
        cnt_inc     = r_count + CNT_W'(1);
        hit         = 1'b0;

        unique case (r_in.op)
            OP_LOAD: begin
                // End any search; first unit of a new load empties the pattern.
                n_count   = '0;
                n_done    = 1'b0;
                n_loading = !r_in.last;
                n_len     = len_base;
                if (len_base < LEN_W'(PATTERN_MAX)) begin
                    w_pat_shift = 1'b1;
                    n_len       = len_base + LEN_W'(1);
                end
            end
            OP_TEXT: begin
                n_loading = 1'b0;
                n_offset  = offset;
                if (!done && (r_count < CNT_W'(TEXT_MAX))) begin
                    w_win_shift = 1'b1;
                    n_count     = cnt_inc;
                    if (r_len == '0) begin
                        hit   = CMP_W'(cnt_inc) >= CMP_W'(offset);
                        n_pos = offset;
                    end else begin
                        hit   = w_match &&
                                (CMP_W'(cnt_inc) >= CMP_W'(r_len) + CMP_W'(offset));
                        n_pos = POS_W'(CMP_W'(cnt_inc) - CMP_W'(r_len));
                    end
                end
                n_done  = done || hit;
                n_found = hit;
                w_emit  = hit;
                if (r_in.last) begin
                    // Report not-found unless a match was already given.
                    if (!(done || hit)) begin
                        w_emit = 1'b1;
                        n_pos  = '0;
                    end
                    n_count = '0;
                    n_done  = 1'b0;
                end
            end
            OP_CLEAR: begin
                n_count   = '0;
                n_done    = 1'b0;
                n_len     = '0;
                n_loading = 1'b0;
            end
            default: begin
                // Unused op: drop the beat.
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_loading   <= 1'b0;
            r_count     <= '0;
            r_offset    <= '0;
            r_done      <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_fire) begin
                r_len     <= n_len;
                r_loading <= n_loading;
                r_count   <= n_count;
                r_offset  <= n_offset;
                r_done    <= n_done;
            end
            if (w_fire && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_fire && w_pat_shift) begin
            r_pat <= n_pat;
        end
        if (w_fire && w_win_shift) begin
            r_window <= n_window;
        end
        if (w_fire && w_emit) begin
            r_found <= n_found;
            r_pos   <= n_pos;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.data.found    = r_found;
    assign o_res.data.position = r_pos;

endmodule

// ===== tb/u16ss_match_check.sv =====
`timescale 1ns / 1ps
// Result checker for the substring search: predicts every result beat and compares it.
module u16ss_match_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  u16ss_pkg::t_in_beat  i_in_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  u16ss_pkg::t_res_beat i_res_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    import u16ss_pkg::*;

    logic [UNIT_W-1:0] pat_units [PATTERN_MAX];
    logic [UNIT_W-1:0] recent    [PATTERN_MAX];   // newest text unit at index 0
    int                pat_len;
    bit                pat_open;
    int                units_seen;                // 0: no search under way
    int                from_pos;
    bit                hit;
    t_res_beat         search_results [$];
    t_res_beat         oldest;

    task automatic report(input string what);
        $display("%0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    // Advance the search state by one accepted beat; queue the result it causes.
    task automatic predict_search(input t_in_beat b);
        int s;
        int k;
        bit same;
        case (b.op)
            OP_LOAD: begin
                units_seen = 0;
                hit        = 1'b0;
                if (!pat_open) begin
                    pat_len  = 0;
                    pat_open = 1'b1;
                end
                if (pat_len < PATTERN_MAX) begin
                    pat_units[pat_len] = b.ch;
                    pat_len++;
                end
                if (b.last) pat_open = 1'b0;
            end
            OP_CLEAR: begin
                units_seen = 0;
                hit        = 1'b0;
                pat_len    = 0;
                pat_open   = 1'b0;
            end
            OP_TEXT: begin
                pat_open = 1'b0;
                if (units_seen == 0) begin
                    from_pos = b.start_at;
                    hit      = 1'b0;
                end
                if (!hit && units_seen < TEXT_MAX) begin
                    for (k = PATTERN_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
                    recent[0] = b.ch;
                    units_seen++;
                    if (pat_len == 0) begin
                        if (units_seen >= from_pos) begin
                            search_results.push_back('{found: 1'b1, position: POS_W'(from_pos)});
                            hit = 1'b1;
                        end
                    end else if (units_seen >= pat_len) begin
                        s    = units_seen - pat_len;
                        same = 1'b1;
                        for (k = 0; k < pat_len; k++) begin
                            if (recent[k] != pat_units[pat_len-1-k]) same = 1'b0;
                        end
                        if (s >= from_pos && same) begin
                            search_results.push_back('{found: 1'b1, position: POS_W'(s)});
                            hit = 1'b1;
                        end
                    end
                end
                if (b.last) begin
                    if (!hit) search_results.push_back('{found: 1'b0, position: '0});
                    units_seen = 0;
                    hit        = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_len    = 0;
            pat_open   = 1'b0;
            units_seen = 0;
            from_pos   = 0;
            hit        = 1'b0;
            foreach (recent[i]) recent[i] = '0;
            search_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (search_results.size() == 0) begin
                    report($sformatf("unexpected result found=%b position=%0d",
                                     i_res_data.found, i_res_data.position));
                end else begin
                    oldest = search_results.pop_front();
                    if (i_res_data.found !== oldest.found)
                        report($sformatf("found flag %b, expected %b",
                                         i_res_data.found, oldest.found));
                    if (i_res_data.position !== oldest.position)
                        report($sformatf("position %0d, expected %0d",
                                         i_res_data.position, oldest.position));
                end
            end
            if (i_in_valid && i_in_ready) predict_search(i_in_data);
        end
        o_pending = search_results.size();
    end

endmodule

// ===== tb/utf16_substring_search_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives directed and random beats into the search block and gives the verdict.
module utf16_substring_search_tb;
    import u16ss_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RANDOM_BEATS = 1900;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 10;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_req       = 1'b0;
    int          fail_count;
    int          pending;
    int          beats_sent     = 0;
    // Pattern as the stimulus last loaded it, used to plant occurrences in text.
    logic [15:0] cur_pattern [$];
    bit          load_open      = 1'b0;

    u16ss_in_if  in_ch ();
    u16ss_res_if res_ch ();

    utf16_substring_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    u16ss_match_check match_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: stall at the phase's rate; on request hold ready low for a long stretch.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [15:0] pick_unit(input bit wide);
        // Narrow units come from a two-letter alphabet so partial matches are common.
        return wide ? 16'($urandom) : 16'h0041 + 16'($urandom_range(1));
    endfunction

    // Offer one beat, starting at a falling edge; return at the falling edge after acceptance.
    task automatic send_beat(input logic [1:0] b_op, input logic [15:0] b_unit,
                             input logic b_last, input logic [15:0] b_start);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.data  = '{op: b_op, ch: b_unit, last: b_last, start_at: b_start};
        in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (b_op != OP_UNUSED) beats_sent++;
    endtask

    // Load pattern units; with keep_open the final unit carries no last flag.
    task automatic load_pattern(input logic [15:0] units [$], input bit keep_open);
        int k;
        if (!load_open) cur_pattern.delete();
        for (k = 0; k < units.size(); k++) begin
            send_beat(OP_LOAD, units[k], !keep_open && k == units.size() - 1, 16'($urandom));
            if (cur_pattern.size() < PATTERN_MAX) cur_pattern.push_back(units[k]);
        end
        load_open = keep_open;
    endtask

    // Mostly well-formed load/search sequences; the rest clears, noise and cut-off texts.
    task automatic random_traffic(input int budget);
        int          goal;
        int          r;
        int          len;
        int          plant_at;
        int          k;
        bit          wide;
        bit          cut;
        logic [15:0] start;
        logic [15:0] units [$];
        goal = beats_sent + budget;
        while (beats_sent < goal) begin
            r    = $urandom_range(99);
            wide = ($urandom_range(3) == 0);
            units.delete();
            if (r < 6) begin
                // noise: any op code, any fields
                send_beat(2'($urandom_range(3)), 16'($urandom), 1'($urandom_range(1)),
                          16'($urandom));
            end else if (r < 14) begin
                send_beat(OP_CLEAR, 16'($urandom), 1'($urandom_range(1)), 16'($urandom));
                cur_pattern.delete();
                load_open = 1'b0;
            end else if (r < 40) begin
                // now and then a pattern longer than the block holds
                len = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
                for (k = 0; k < len; k++) units.push_back(pick_unit(wide));
                load_pattern(units, $urandom_range(7) == 0);
            end else begin
                len = $urandom_range(1, 20) + cur_pattern.size();
                for (k = 0; k < len; k++) units.push_back(pick_unit(wide));
                if ($urandom_range(1) == 1) begin
                    plant_at = $urandom_range(0, len - cur_pattern.size());
                    for (k = 0; k < cur_pattern.size(); k++) units[plant_at + k] = cur_pattern[k];
                end
                start = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, len));
                cut   = ($urandom_range(11) == 0);
                // start offset counts only on the first unit; scramble it on the rest
                for (k = 0; k < len; k++) begin
                    if (cut && k == len - 1) break;
                    send_beat(OP_TEXT, units[k], k == len - 1, (k == 0) ? start : 16'($urandom));
                end
                load_open = 1'b0;
            end
        end
    endtask

    initial begin
        int ph;
        int unsigned idle_by_phase  [4] = '{0, 55, 0, 7};
        int unsigned stall_by_phase [4] = '{0, 0, 55, 7};

        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_rst_n     = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats, no idling.
        // empty pattern, start 0: match on the first unit
        send_beat(OP_TEXT, 16'hFFFF, 1'b1, 16'h0000);
        // empty pattern, start 2: match on the second unit, final unit stays silent
        send_beat(OP_TEXT, 16'h0000, 1'b0, 16'h0002);
        send_beat(OP_TEXT, 16'h1234, 1'b0, 16'hFFFF);
        send_beat(OP_TEXT, 16'h0001, 1'b1, 16'h0000);
        // empty pattern, start beyond the text: not found
        send_beat(OP_TEXT, 16'h5555, 1'b1, 16'hFFFF);
        load_pattern({16'h0041, 16'h0042}, 1'b0);
        // match at 1
        send_beat(OP_TEXT, 16'h0041, 1'b0, 16'h0000);
        send_beat(OP_TEXT, 16'h0041, 1'b0, 16'h0000);
        send_beat(OP_TEXT, 16'h0042, 1'b0, 16'h0000);
        send_beat(OP_TEXT, 16'h0042, 1'b1, 16'h0000);
        // occurrence before the start offset is skipped, match at 2
        send_beat(OP_TEXT, 16'h0041, 1'b0, 16'h0002);
        send_beat(OP_TEXT, 16'h0042, 1'b0, 16'h0000);
        send_beat(OP_TEXT, 16'h0041, 1'b0, 16'h0000);
        send_beat(OP_TEXT, 16'h0042, 1'b1, 16'h0000);
        // pattern longer than the text
        send_beat(OP_TEXT, 16'h0041, 1'b1, 16'h0000);
        // new load left open, then text ends it with one unit kept
        load_pattern({16'h0043}, 1'b1);
        send_beat(OP_TEXT, 16'h0043, 1'b0, 16'h0000);
        send_beat(OP_TEXT, 16'h0000, 1'b1, 16'h0000);
        // search abandoned by a clear, then an empty-pattern search at start 1
        send_beat(OP_TEXT, 16'h0043, 1'b0, 16'h0001);
        send_beat(OP_CLEAR, 16'h0000, 1'b0, 16'h0000);
        cur_pattern.delete();
        send_beat(OP_TEXT, 16'h0007, 1'b1, 16'h0001);
        // unused op code, all bits set
        send_beat(OP_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF);
        load_open = 1'b0;

        // Random traffic over the idling phases.
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_by_phase[ph];
            recv_stall_pct = stall_by_phase[ph];
            random_traffic(RANDOM_BEATS / 4);
            if (ph == 1) begin
                // Hold off the result side while one-unit texts keep coming,
                // so the block fills and stalls; then pause until all drained.
                send_idle_pct = 0;
                hold_req      = 1'b1;
                repeat (24) send_beat(OP_TEXT, pick_unit(1'b0), 1'b1, 16'h0000);
                load_open   = 1'b0;
                in_ch.valid = 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
        end

        // Drop valid, let the last results drain, then a few more cycles.
        in_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
